// ----- rtl/csd_pkg.sv -----
package csd_pkg;

    localparam int CFG_W = 5;
    localparam int OP_W  = 2;
    localparam int PC_W  = 4;
    localparam int COEF_W = 64;

    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
    localparam logic [OP_W-1:0] OP_INCLUDE   = 2'd1;
    localparam logic [OP_W-1:0] OP_DECREMENT = 2'd2;

    localparam logic [CFG_W-1:0] CLIQUE_RESET = 5'd3;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_READ_H,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_COMBINE,
        DP_ADDX,
        DP_FSUB,
        DP_WRITE,
        DP_READ_OUT,
        DP_OUT,
        DP_CLEAR
    } t_dpop;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOREQ,
        C_OPCLR,
        C_OPNOP,
        C_OPINC,
        C_NOTLAST,
        C_OUTBUSY
    } t_cond;

    typedef struct packed {
        t_dpop op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic req_valid;
        logic op_clr;
        logic op_nop;
        logic op_inc;
        logic last;
        logic out_busy;
    } t_stat;

    localparam t_pc PC_WAIT = 4'd0;
    localparam t_pc PC_DISC = 4'd1;
    localparam t_pc PC_DISN = 4'd2;
    localparam t_pc PC_RD   = 4'd3;
    localparam t_pc PC_MLO  = 4'd4;
    localparam t_pc PC_MHI  = 4'd5;
    localparam t_pc PC_CMB  = 4'd6;
    localparam t_pc PC_ADDX = 4'd7;
    localparam t_pc PC_FSUB = 4'd8;
    localparam t_pc PC_WR   = 4'd9;
    localparam t_pc PC_ORD  = 4'd10;
    localparam t_pc PC_OUT  = 4'd11;
    localparam t_pc PC_END  = 4'd12;
    localparam t_pc PC_CLR  = 4'd13;

    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        case (pc)
            PC_WAIT: w = '{op: DP_LATCH,    cond: C_NOREQ,   target: PC_WAIT};
            PC_DISC: w = '{op: DP_NONE,     cond: C_OPCLR,   target: PC_CLR};
            PC_DISN: w = '{op: DP_NONE,     cond: C_OPNOP,   target: PC_ORD};
            PC_RD:   w = '{op: DP_READ_H,   cond: C_NEVER,   target: PC_WAIT};
            PC_MLO:  w = '{op: DP_MUL_LO,   cond: C_NEVER,   target: PC_WAIT};
            PC_MHI:  w = '{op: DP_MUL_HI,   cond: C_NEVER,   target: PC_WAIT};
            PC_CMB:  w = '{op: DP_COMBINE,  cond: C_OPINC,   target: PC_WR};
            PC_ADDX: w = '{op: DP_ADDX,     cond: C_NEVER,   target: PC_WAIT};
            PC_FSUB: w = '{op: DP_FSUB,     cond: C_NEVER,   target: PC_WAIT};
            PC_WR:   w = '{op: DP_WRITE,    cond: C_NOTLAST, target: PC_RD};
            PC_ORD:  w = '{op: DP_READ_OUT, cond: C_NEVER,   target: PC_WAIT};
            PC_OUT:  w = '{op: DP_OUT,      cond: C_OUTBUSY, target: PC_OUT};
            PC_END:  w = '{op: DP_NONE,     cond: C_ALWAYS,  target: PC_WAIT};
            PC_CLR:  w = '{op: DP_CLEAR,    cond: C_ALWAYS,  target: PC_ORD};
            default: w = '{op: DP_NONE,     cond: C_ALWAYS,  target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/csd_req_if.sv -----
interface csd_req_if #(
    parameter int COUNT_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             operation;
    logic [COUNT_WIDTH-1:0] count;

    modport source (output valid, operation, count, input ready);
    modport sink (input valid, operation, count, output ready);
endinterface

// ----- rtl/csd_rsp_if.sv -----
interface csd_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] star_degree;
    logic        saturated;

    modport source (output valid, star_degree, saturated, input ready);
    modport sink (input valid, star_degree, saturated, output ready);
endinterface

// ----- rtl/colorful_star_degree_update.sv -----
// Keeps the truncated coefficients of a product of (1 + count*x) factors and returns the
// top one (degree k-1, k the clique size clamped to 2..MAX_STAR) with a sticky
// saturation flag for every request. A microcoded sequencer steps one coefficient at a
// time through a 32 x COUNT_WIDTH multiplier (two passes per 64-bit product) and one
// shared saturating adder, with the coefficients in a memory read one address per cycle.
// Each coefficient 1..k-1 is read, multiplied, combined (for a decrement also added and
// floor-subtracted) and written; clear and unused operations skip this. One request is
// in work at a time; the next is taken while the last result still waits for output.
module colorful_star_degree_update
    import csd_pkg::*;
#(
    parameter int MAX_STAR    = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    csd_req_if.sink          i_req,
    csd_rsp_if.source        o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dpop dp_op;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    csd_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_op    (dp_op)
    );

    csd_datapath #(
        .MAX_STAR    (MAX_STAR),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (dp_op),
        .o_stat        (stat),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (i_req.ready),
        .i_operation   (i_req.operation),
        .i_count       (i_req.count),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_star_degree (o_rsp.star_degree),
        .o_saturated   (o_rsp.saturated)
    );

endmodule

// ----- rtl/csd_useq.sv -----
module csd_useq
    import csd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_dpop o_op
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   take;

    always_comb begin
        uw = ucode(r_pc);
        case (uw.cond)
            C_NEVER:   take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_NOREQ:   take = !i_stat.req_valid;
            C_OPCLR:   take = i_stat.op_clr;
            C_OPNOP:   take = i_stat.op_nop;
            C_OPINC:   take = i_stat.op_inc;
            C_NOTLAST: take = !i_stat.last;
            C_OUTBUSY: take = i_stat.out_busy;
            default:   take = 1'b1;
        endcase
        n_pc = take ? uw.target : r_pc + t_pc'(1);
        o_op = uw.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- rtl/csd_datapath.sv -----
module csd_datapath
    import csd_pkg::*;
#(
    parameter int MAX_STAR    = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dpop                  i_op,
    output t_stat                  o_stat,
    input  logic                   i_req_valid,
    output logic                   o_req_ready,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic                   i_cfg_valid,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_rsp_ready,
    output logic                   o_rsp_valid,
    output logic [COEF_W-1:0]      o_star_degree,
    output logic                   o_saturated
);

    localparam int AW  = $clog2(MAX_STAR);
    localparam int PLW = 32 + COUNT_WIDTH;
    localparam int PW  = COEF_W + COUNT_WIDTH;

    logic [COEF_W-1:0]      mem [MAX_STAR];
    logic [MAX_STAR-1:0]    r_vld;
    logic [CFG_W-1:0]       r_clique_size;
    logic [OP_W-1:0]        r_op;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [AW-1:0]          r_h;
    logic [COEF_W-1:0]      r_x;
    logic [COEF_W-1:0]      r_a;
    logic [PLW-1:0]         r_plo;
    logic [PLW-1:0]         r_phi;
    logic [COEF_W-1:0]      r_p;
    logic [COEF_W-1:0]      r_q;
    logic                   r_sat;
    logic [COEF_W-1:0]      r_rd_data;
    logic                   r_rd_vld;
    logic                   r_out_valid;
    logic [COEF_W-1:0]      r_out_deg;
    logic                   r_out_sat;

    logic [AW-1:0]     km1;
    logic [AW-1:0]     rd_addr;
    logic [31:0]       mul_in;
    logic [PLW-1:0]    mul_prod;
    logic [PW-1:0]     full;
    logic              mul_ovf;
    logic [COEF_W-1:0] sa_a;
    logic [COEF_W-1:0] sa_b;
    logic [COEF_W:0]   sa_sum;
    logic [COEF_W-1:0] sa_res;
    logic [COEF_W-1:0] base;
    logic              sub_neg;
    logic              accept;
    logic              out_busy;
    logic              op_inc;

    always_comb begin
        if (r_clique_size < CFG_W'(2)) begin
            km1 = AW'(1);
        end else if (32'(r_clique_size) > MAX_STAR) begin
            km1 = AW'(MAX_STAR - 1);
        end else begin
            km1 = AW'(r_clique_size) - AW'(1);
        end
    end

    assign op_inc   = (r_op == OP_INCLUDE);
    assign accept   = (i_op == DP_LATCH) && i_req_valid;
    assign out_busy = r_out_valid && !i_rsp_ready;
    assign rd_addr  = (i_op == DP_READ_OUT) ? km1 : r_h;
    assign base     = op_inc ? r_a : r_q;

    assign mul_in   = (i_op == DP_MUL_HI) ? r_x[COEF_W-1:32] : r_x[31:0];
    assign mul_prod = PLW'(mul_in) * PLW'(r_count);

    assign full    = (PW'(r_phi) << 32) + PW'(r_plo);
    assign mul_ovf = |full[PW-1:COEF_W];
    assign sub_neg = r_q > r_a;

    always_comb begin
        if (i_op == DP_ADDX) begin
            sa_a = r_p;
            sa_b = r_x;
        end else begin
            sa_a = base;
            sa_b = r_p;
        end
        sa_sum = {1'b0, sa_a} + {1'b0, sa_b};
        sa_res = sa_sum[COEF_W] ? '1 : sa_sum[COEF_W-1:0];
    end

    always_comb begin
        o_stat.req_valid = i_req_valid;
        o_stat.op_clr    = (r_op == OP_CLEAR);
        o_stat.op_inc    = op_inc;
        o_stat.op_nop    = !((r_op == OP_CLEAR) || op_inc || (r_op == OP_DECREMENT));
        o_stat.last      = (r_h == km1);
        o_stat.out_busy  = out_busy;
    end

    assign o_req_ready   = (i_op == DP_LATCH);
    assign o_rsp_valid   = r_out_valid;
    assign o_star_degree = r_out_deg;
    assign o_saturated   = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (i_op == DP_WRITE) begin
            mem[r_h] <= sa_res;
        end
        if (i_op == DP_READ_H || i_op == DP_READ_OUT) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_clique_size <= CLIQUE_RESET;
            r_op          <= OP_CLEAR;
            r_h           <= AW'(1);
            r_sat         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_rd_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_clique_size <= i_cfg_data;
            end
            if (i_op == DP_READ_H || i_op == DP_READ_OUT) begin
                r_rd_vld <= r_vld[rd_addr];
            end
            case (i_op)
                DP_LATCH: begin
                    if (accept) begin
                        r_op <= i_operation;
                        r_h  <= AW'(1);
                    end
                end
                DP_COMBINE: begin
                    if (mul_ovf) begin
                        r_sat <= 1'b1;
                    end
                end
                DP_ADDX: begin
                    if (sa_sum[COEF_W]) begin
                        r_sat <= 1'b1;
                    end
                end
                DP_FSUB: begin
                    if (sub_neg) begin
                        r_sat <= 1'b1;
                    end
                end
                DP_WRITE: begin
                    r_vld[r_h] <= 1'b1;
                    r_h        <= r_h + AW'(1);
                    if (sa_sum[COEF_W]) begin
                        r_sat <= 1'b1;
                    end
                end
                DP_CLEAR: begin
                    r_vld <= '0;
                    r_sat <= 1'b0;
                end
                default: begin
                end
            endcase
            if (i_op == DP_OUT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LATCH: begin
                if (accept) begin
                    r_count <= i_count;
                    r_x     <= COEF_W'(1);
                end
            end
            DP_MUL_LO: begin
                r_a   <= r_rd_vld ? r_rd_data : '0;
                r_plo <= mul_prod;
            end
            DP_MUL_HI: begin
                r_phi <= mul_prod;
            end
            DP_COMBINE: begin
                r_p <= mul_ovf ? '1 : full[COEF_W-1:0];
            end
            DP_ADDX: begin
                r_q <= sa_res;
            end
            DP_FSUB: begin
                r_q <= sub_neg ? '0 : r_a - r_q;
            end
            DP_WRITE: begin
                r_x <= base;
            end
            DP_OUT: begin
                if (!out_busy) begin
                    r_out_deg <= r_rd_vld ? r_rd_data : '0;
                    r_out_sat <= r_sat;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/csd_checker.sv -----
module csd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [63:0] i_star_degree,
    input logic        i_saturated
);

    logic req_acc;

    assign req_acc = i_req_valid && i_req_ready;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_star_degree) && $stable(i_saturated))
        else $error("response payload changed while stalled");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req_ready)
        else $error("second request taken while one is in work");

    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !$rose(i_rsp_valid))
        else $error("response appeared the cycle after a request");

    a_rsp_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !i_req_ready)
        else $error("request port open in the cycle a response is issued");

endmodule

bind colorful_star_degree_update csd_checker u_csd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_star_degree (o_rsp.star_degree),
    .i_saturated   (o_rsp.saturated)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import csd_pkg::*;

    localparam int MAX_STAR    = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int TAIL_CYCLES = 128;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_ITEMS = 1750;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [COEF_W-1:0] degree;
        logic              saturated;
    } t_star_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    csd_req_if #(.COUNT_WIDTH(COUNT_WIDTH)) req_bus ();
    csd_rsp_if rsp_bus ();

    colorful_star_degree_update #(
        .MAX_STAR   (MAX_STAR),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    logic [COEF_W-1:0] poly_coef [MAX_STAR];
    logic              poly_saturated;
    logic [CFG_W-1:0]  clique_reg;

    t_star_result expected_degrees [$];

    int failures;
    int requests_sent;
    int results_checked;
    int saturated_results;
    int settings_used;
    int cycle_count;
    int stall_left;
    bit steady_flow;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d requests outstanding", $time,
                     expected_degrees.size());
            $display("** colorful_star_degree_update: FAILED **");
            $finish;
        end
    end

    function automatic logic [COEF_W-1:0] mul_sat(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b);
        logic [2*COEF_W-1:0] p;
        p = {{COEF_W{1'b0}}, a} * {{COEF_W{1'b0}}, b};
        if (p[2*COEF_W-1:COEF_W] != '0) begin
            poly_saturated = 1'b1;
            return '1;
        end
        return p[COEF_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] add_sat(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b);
        logic [COEF_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COEF_W]) begin
            poly_saturated = 1'b1;
            return '1;
        end
        return s[COEF_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] sub_floor(logic [COEF_W-1:0] a,
                                                     logic [COEF_W-1:0] b);
        if (b > a) begin
            poly_saturated = 1'b1;
            return '0;
        end
        return a - b;
    endfunction

    function automatic void clear_poly();
        for (int h = 0; h < MAX_STAR; h++)
            poly_coef[h] = '0;
        poly_coef[0] = COEF_W'(1);
        poly_saturated = 1'b0;
    endfunction

    function automatic t_star_result predict_star_degree(logic [OP_W-1:0] op,
                                                         logic [COUNT_WIDTH-1:0] cnt);
        int k;
        logic [COEF_W-1:0] c;
        logic [COEF_W-1:0] quo [MAX_STAR];
        t_star_result res;
        c = COEF_W'(cnt);
        k = int'(clique_reg);
        if (k < 2)
            k = 2;
        if (k > MAX_STAR)
            k = MAX_STAR;
        case (op)
            OP_CLEAR: begin
                clear_poly();
            end
            OP_INCLUDE: begin
                for (int h = k - 1; h > 0; h--)
                    poly_coef[h] = add_sat(poly_coef[h], mul_sat(poly_coef[h-1], c));
            end
            OP_DECREMENT: begin
                quo[0] = COEF_W'(1);
                for (int h = 1; h < k; h++)
                    quo[h] = sub_floor(poly_coef[h], mul_sat(quo[h-1], c + COEF_W'(1)));
                for (int h = 1; h < k; h++)
                    poly_coef[h] = add_sat(quo[h], mul_sat(quo[h-1], c));
            end
            default: begin
            end
        endcase
        poly_coef[0] = COEF_W'(1);
        res.degree = poly_coef[k-1];
        res.saturated = poly_saturated;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 9);
        if (r < 90)
            return $urandom_range(10, 300);
        return $urandom_range(0, 65535);
    endfunction

    always @(posedge i_clk) begin
        t_star_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_degrees.size() == 0) begin
                $display("%0t: unexpected result, got star_degree %0d saturated %0b",
                         $time, rsp_bus.star_degree, rsp_bus.saturated);
                failures++;
            end else begin
                want = expected_degrees.pop_front();
                results_checked++;
                if (rsp_bus.saturated === 1'b1)
                    saturated_results++;
                if (rsp_bus.star_degree !== want.degree) begin
                    $display("%0t: star_degree mismatch, expected %0d, got %0d", $time,
                             want.degree, rsp_bus.star_degree);
                    failures++;
                end
                if (rsp_bus.saturated !== want.saturated) begin
                    $display("%0t: saturated mismatch, expected %0b, got %0b", $time,
                             want.saturated, rsp_bus.saturated);
                    failures++;
                end
            end
        end
    end

    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_bus.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input int cnt);
        int gap;
        @(negedge i_clk);
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.count     <= COUNT_WIDTH'(cnt);
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        expected_degrees.push_back(predict_star_degree(op, COUNT_WIDTH'(cnt)));
        requests_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (expected_degrees.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_clique_size(input logic [CFG_W-1:0] value);
        drain_requests();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        clique_reg = value;
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(OP_INCLUDE, 7);
        send_request(OP_INCLUDE, 5);
    endtask

    task automatic test_saturation();
        write_clique_size(CFG_W'(5));
        send_request(OP_CLEAR, 0);
        repeat (5) send_request(OP_INCLUDE, 65535);
        send_request(OP_DECREMENT, 65534);
        send_request(OP_CLEAR, 0);
        send_request(OP_UNUSED, 12345);
    endtask

    task automatic test_underflow();
        send_request(OP_CLEAR, 0);
        send_request(OP_DECREMENT, 0);
    endtask

    task automatic test_clique_change();
        write_clique_size(CFG_W'(4));
        send_request(OP_CLEAR, 0);
        send_request(OP_INCLUDE, 2);
        send_request(OP_INCLUDE, 3);
        send_request(OP_INCLUDE, 4);
        write_clique_size(CFG_W'(2));
        send_request(OP_INCLUDE, 5);
        write_clique_size(CFG_W'(4));
        send_request(OP_UNUSED, 0);
    endtask

    task automatic test_clique_extremes();
        write_clique_size(CFG_W'(0));
        send_request(OP_INCLUDE, 65535);
        send_request(OP_DECREMENT, 65535);
        write_clique_size(CFG_W'(31));
        send_request(OP_CLEAR, 0);
        send_request(OP_INCLUDE, 1);
        send_request(OP_DECREMENT, 0);
    endtask

    task automatic run_vertex_sequence();
        int ncolors;
        int ndec;
        int idx;
        int color_count [20];
        send_request(OP_CLEAR, 0);
        ncolors = $urandom_range(1, 18);
        for (int i = 0; i < ncolors; i++) begin
            color_count[i] = pick_count();
            send_request(OP_INCLUDE, color_count[i]);
        end
        ndec = $urandom_range(0, 3 * ncolors);
        for (int j = 0; j < ndec; j++) begin
            idx = $urandom_range(0, ncolors - 1);
            if ($urandom_range(0, 15) == 0) begin
                send_request(OP_DECREMENT, $urandom_range(0, 65535));
            end else if (color_count[idx] > 0) begin
                color_count[idx]--;
                send_request(OP_DECREMENT, color_count[idx]);
            end
        end
    endtask

    task automatic run_noise(input int n);
        for (int i = 0; i < n; i++)
            send_request(OP_W'($urandom_range(0, 3)),
                         ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : pick_count());
    endtask

    task automatic test_random_vertices();
        int target;
        int setting [10];
        setting = '{16, 2, 31, 0, 1, 3, 0, 0, 0, 0};
        for (int p = 6; p < 10; p++)
            setting[p] = $urandom_range(0, 31);
        for (int p = 0; p < 10; p++) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            write_clique_size(CFG_W'(setting[p]));
            target = requests_sent + RANDOM_ITEMS / 10;
            while (requests_sent < target) begin
                if ($urandom_range(0, 3) != 0)
                    run_vertex_sequence();
                else
                    run_noise($urandom_range(1, 8));
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.operation = OP_CLEAR;
        req_bus.count = '0;
        failures = 0;
        requests_sent = 0;
        results_checked = 0;
        saturated_results = 0;
        settings_used = 0;
        cycle_count = 0;
        stall_left = 0;
        steady_flow = 1'b0;
        clique_reg = CLIQUE_RESET;
        clear_poly();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation();
        test_underflow();
        test_clique_change();
        test_clique_extremes();
        test_random_vertices();

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_degrees.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_degrees.size());
            failures++;
        end
        $display("Sent %0d requests across %0d clique-size writes;", requests_sent,
                 settings_used);
        $display("checked %0d results, %0d with the saturation flag set.", results_checked,
                 saturated_results);
        if (failures == 0) begin
            $display("** colorful_star_degree_update: PASSED **");
        end else begin
            $display("** colorful_star_degree_update: FAILED **");
        end
        $finish;
    end

endmodule
